/* rtl/core/lprm_pkg.sv */
// Shared constants, field widths and types of the longest prefix route matcher.
// No dependencies; every other file but lprm_ram imports this package.
package lprm_pkg;

	localparam int NUM_ROUTES = 64;
	localparam int MAX_PREFIX = 128;

	localparam int MODE_W  = 2;
	localparam int ROUTE_W = 6;
	localparam int POS_W   = 7;
	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 7;
	localparam int PATH_W  = 8;

	localparam int PREFIX_AW = (MAX_PREFIX > 1) ? $clog2(MAX_PREFIX) : 1;
	localparam int ROW_W     = NUM_ROUTES * BYTE_W;

	localparam int LANES  = 8;
	localparam int GROUPS = (NUM_ROUTES + LANES - 1) / LANES;
	localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int CAND_N = GROUPS * LANES;

	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PREFIX = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PATH   = 2'd2;

	localparam logic [PATH_W-1:0] PATH_MAX = '1;

	typedef logic [LEN_W-1:0] len_t;
	typedef len_t [CAND_N-1:0] cand_arr_t;

	typedef struct packed {
		logic      start;
		cand_arr_t cand;
	} scan_cmd_t;

endpackage

/* rtl/core/lprm_if.sv */
// Handshake channels of the route matcher: request beats in, match beats out.
// Depends on lprm_pkg for field widths.
interface lprm_in_if;
	import lprm_pkg::*;
	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	logic [ROUTE_W-1:0] route_index;
	logic [POS_W-1:0]   position;
	logic [BYTE_W-1:0]  data_byte;
	logic               last;

	modport source (output valid, mode, route_index, position, data_byte, last, input ready);
	modport sink (input valid, mode, route_index, position, data_byte, last, output ready);
endinterface

interface lprm_out_if;
	import lprm_pkg::*;
	logic               valid;
	logic               ready;
	logic               matched;
	logic [ROUTE_W-1:0] best_route;
	logic [LEN_W-1:0]   best_length;

	modport source (output valid, matched, best_route, best_length, input ready);
	modport sink (input valid, matched, best_route, best_length, output ready);
endinterface

/* rtl/core/lprm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lprm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/core/lprm_scan.sv */
// Winner search over the candidate lengths, LANES routes per cycle (the last group waits for a
// free output register), and the output register of the match channel. Depends on lprm_pkg and lprm_out_if.
module lprm_scan (
	input  logic                clk,
	input  logic                arst_n,
	input  lprm_pkg::scan_cmd_t cmd,
	output logic                busy,
	lprm_out_if.source          rsp
);
	import lprm_pkg::*;

	typedef enum logic {ST_IDLE, ST_SCAN} state_t;

	state_t             state_q;
	logic [GRP_W-1:0]   grp_q;
	cand_arr_t          cand_q;
	len_t               top_len_q;
	logic [ROUTE_W-1:0] best_idx_q;
	logic               out_valid_q;
	logic               out_matched_q;
	logic [ROUTE_W-1:0] out_route_q;
	len_t               out_len_q;

	len_t               cur_len;
	logic [ROUTE_W-1:0] cur_idx;
	logic               last_grp;
	logic               out_free;

	always_comb begin
		cur_len = top_len_q;
		cur_idx = best_idx_q;
		for (int l = 0; l < LANES; l++) begin
			if (cand_q[l] > cur_len) begin
				cur_len = cand_q[l];
				cur_idx = ROUTE_W'(int'(grp_q) * LANES + l);
			end
		end
	end

	assign last_grp = (grp_q == GRP_W'(GROUPS - 1));
	assign out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			grp_q         <= '0;
			cand_q        <= '0;
			top_len_q     <= '0;
			best_idx_q    <= '0;
			out_valid_q   <= 1'b0;
			out_matched_q <= 1'b0;
			out_route_q   <= '0;
			out_len_q     <= '0;
		end else begin
			if (rsp.ready && !((state_q == ST_SCAN) && last_grp)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						cand_q     <= cmd.cand;
						grp_q      <= '0;
						top_len_q  <= '0;
						best_idx_q <= '0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (!last_grp) begin
						for (int i = 0; i < CAND_N - LANES; i++) begin
							cand_q[i] <= cand_q[i + LANES];
						end
						for (int i = CAND_N - LANES; i < CAND_N; i++) begin
							cand_q[i] <= '0;
						end
						top_len_q  <= cur_len;
						best_idx_q <= cur_idx;
						grp_q      <= grp_q + 1'b1;
					end else if (out_free) begin
						out_valid_q   <= 1'b1;
						out_matched_q <= (cur_len != '0);
						out_route_q   <= cur_idx;
						out_len_q     <= cur_len;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy            = (state_q != ST_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.matched     = out_matched_q;
	assign rsp.best_route  = out_route_q;
	assign rsp.best_length = out_len_q;

endmodule

/* rtl/core/longest_prefix_route_match.sv */
// Top level of the longest prefix route matcher: prefix row RAM, compare stage,
// route lengths and alive mask. Depends on lprm_pkg, lprm_if, lprm_ram, lprm_scan.
//
//   channel  dir  beat fields
//   req      in   mode, route_index, position, data_byte, last
//   rsp      out  matched, best_route, best_length
//
// Path bytes stream back to back through the RAM read and the compare stage. A prefix
// byte does a read-modify-write of a row, and req.ready is low while it writes.
// A final path byte adds a winner search over LANES routes a cycle in GROUPS groups
// (8 for 64 routes), the last waiting for a free output register; req.ready is low
// meanwhile. Reset clears all lengths, rearms the path and empties the output register;
// no clearing pass is needed. A stalled rsp holds its beat; the next request is taken meanwhile.
module longest_prefix_route_match (
	input  logic      clk,
	input  logic      arst_n,
	lprm_in_if.sink   req,
	lprm_out_if.source rsp
);
	import lprm_pkg::*;

	logic                 accept;
	logic [PATH_W-1:0]    path_pos_q;

	logic                 valid_s1;
	logic [MODE_W-1:0]    mode_s1;
	logic [ROUTE_W-1:0]   route_s1;
	logic [POS_W-1:0]     pos_s1;
	logic [BYTE_W-1:0]    byte_s1;
	logic                 last_s1;
	logic [PATH_W-1:0]    path_s1;

	len_t                 len_q [NUM_ROUTES];
	logic [NUM_ROUTES-1:0] alive_q;
	logic [NUM_ROUTES-1:0] alive_nx;

	logic [PREFIX_AW-1:0] rd_addr;
	logic [ROW_W-1:0]     rd_row;
	logic [ROW_W-1:0]     wr_row;
	logic                 wr_ok;
	logic                 wr_en;
	logic                 pfx_s1;
	logic                 path_byte_s1;
	logic                 path_end_s1;
	logic [PATH_W:0]      path_len;
	logic                 scan_busy;
	scan_cmd_t            scan_cmd;

	assign pfx_s1       = valid_s1 && (mode_s1 == MODE_PREFIX);
	assign path_byte_s1 = valid_s1 && (mode_s1 == MODE_PATH);
	assign path_end_s1  = path_byte_s1 && last_s1;

	assign req.ready = !scan_busy && !pfx_s1 && !path_end_s1;
	assign accept    = req.valid && req.ready;

	assign rd_addr = (req.mode == MODE_PREFIX) ? PREFIX_AW'(req.position)
	                                           : path_pos_q[PREFIX_AW-1:0];

	assign wr_ok = (int'(route_s1) < NUM_ROUTES) && (int'(pos_s1) < MAX_PREFIX - 1);
	assign wr_en = pfx_s1 && wr_ok;

	always_comb begin
		for (int r = 0; r < NUM_ROUTES; r++) begin
			wr_row[r*BYTE_W +: BYTE_W] = (int'(route_s1) == r) ? byte_s1
			                                                   : rd_row[r*BYTE_W +: BYTE_W];
		end
	end

	lprm_ram #(
		.WIDTH(ROW_W),
		.DEPTH(MAX_PREFIX)
	) u_rows (
		.clk    (clk),
		.rd_en  (accept),
		.rd_addr(rd_addr),
		.rd_data(rd_row),
		.wr_en  (wr_en),
		.wr_addr(PREFIX_AW'(pos_s1)),
		.wr_data(wr_row)
	);

	assign path_len = (PATH_W+1)'(path_s1) + 1'b1;

	always_comb begin
		for (int r = 0; r < NUM_ROUTES; r++) begin
			alive_nx[r] = alive_q[r];
			if (path_byte_s1 && (path_s1 < PATH_W'(len_q[r])) && (int'(path_s1) < MAX_PREFIX)
			    && (rd_row[r*BYTE_W +: BYTE_W] != byte_s1)) begin
				alive_nx[r] = 1'b0;
			end
		end
		scan_cmd.start = path_end_s1;
		for (int i = 0; i < CAND_N; i++) begin
			scan_cmd.cand[i] = '0;
			if (i < NUM_ROUTES) begin
				if (alive_nx[i] && (len_q[i] != '0) && ((PATH_W+1)'(len_q[i]) <= path_len)) begin
					scan_cmd.cand[i] = len_q[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			path_pos_q <= '0;
			valid_s1   <= 1'b0;
			mode_s1    <= '0;
			route_s1   <= '0;
			pos_s1     <= '0;
			byte_s1    <= '0;
			last_s1    <= 1'b0;
			path_s1    <= '0;
			alive_q    <= '1;
			for (int r = 0; r < NUM_ROUTES; r++) begin
				len_q[r] <= '0;
			end
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				mode_s1  <= req.mode;
				route_s1 <= req.route_index;
				pos_s1   <= req.position;
				byte_s1  <= req.data_byte;
				last_s1  <= req.last;
				path_s1  <= path_pos_q;
				if (req.mode == MODE_CLEAR) begin
					path_pos_q <= '0;
				end else if (req.mode == MODE_PATH) begin
					if (req.last) begin
						path_pos_q <= '0;
					end else if (path_pos_q != PATH_MAX) begin
						path_pos_q <= path_pos_q + 1'b1;
					end
				end
			end
			if (valid_s1) begin
				case (mode_s1)
					MODE_CLEAR: begin
						alive_q <= '1;
						for (int r = 0; r < NUM_ROUTES; r++) begin
							len_q[r] <= '0;
						end
					end
					MODE_PREFIX: begin
						for (int r = 0; r < NUM_ROUTES; r++) begin
							if (wr_ok && last_s1 && (int'(route_s1) == r)) begin
								len_q[r] <= LEN_W'(int'(pos_s1) + 1);
							end
						end
					end
					MODE_PATH: begin
						alive_q <= last_s1 ? '1 : alive_nx;
					end
					default: begin
						alive_q <= alive_q;
					end
				endcase
			end
		end
	end

	lprm_scan u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (scan_cmd),
		.busy  (scan_busy),
		.rsp   (rsp)
	);

endmodule

/* tb/tb.sv */
// Self-checking testbench of longest_prefix_route_match: route and path beats are
// queued, driven through the req channel, and each rsp beat is checked against a
// local longest-prefix predictor. Depends on lprm_pkg, lprm_if and the RTL top.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lprm_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int ITEM_TARGET = 1700;
	localparam int QUIET_FROM  = 3000;
	localparam int QUIET_TO    = 4500;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [ROUTE_W-1:0] route;
		logic [POS_W-1:0]   pos;
		logic [BYTE_W-1:0]  data;
		logic               last;
		logic               drain;
	} beat_t;

	typedef struct packed {
		logic               matched;
		logic [ROUTE_W-1:0] route;
		len_t               length;
	} match_t;

	logic clk;
	logic arst_n;

	lprm_in_if  req_if ();
	lprm_out_if rsp_if ();

	longest_prefix_route_match u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	beat_t  beat_q[$];
	match_t pending_matches[$];
	beat_t  drv_beat;
	logic   beat_taken;
	int     drv_cycle;
	int     snk_cycle;
	int     hold_left;
	logic   hold_done;
	int     matches_seen;
	int     err_count;
	int     n_items;

	// predictor state
	logic [BYTE_W-1:0]    rt_bytes [NUM_ROUTES][MAX_PREFIX];
	len_t                 rt_len [NUM_ROUTES];
	logic [NUM_ROUTES-1:0] alive;
	logic [PATH_W-1:0]    path_pos;

	// generator mirror
	logic [BYTE_W-1:0] gen_store [NUM_ROUTES][MAX_PREFIX];
	logic              gen_written [NUM_ROUTES][MAX_PREFIX];
	int                gen_len [NUM_ROUTES];
	logic [BYTE_W-1:0] word_buf[$];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	task automatic track_beat(input beat_t b);
		int     win_len;
		int     best_idx;
		int     plen;
		match_t m;
		case (b.mode)
			MODE_CLEAR: begin
				foreach (rt_len[r])
					rt_len[r] = '0;
				alive = '1;
				path_pos = '0;
			end
			MODE_PREFIX: begin
				if (int'(b.pos) < MAX_PREFIX - 1) begin
					rt_bytes[b.route][b.pos] = b.data;
					if (b.last)
						rt_len[b.route] = b.pos + 1'b1;
				end
			end
			MODE_PATH: begin
				for (int r = 0; r < NUM_ROUTES; r++)
					if (int'(path_pos) < int'(rt_len[r]) &&
					    rt_bytes[r][path_pos[POS_W-1:0]] != b.data)
						alive[r] = 1'b0;
				if (!b.last) begin
					if (path_pos != PATH_MAX)
						path_pos = path_pos + 1'b1;
				end else begin
					plen = int'(path_pos) + 1;
					win_len = 0;
					best_idx = 0;
					for (int r = 0; r < NUM_ROUTES; r++)
						if (alive[r] && rt_len[r] != 0 && int'(rt_len[r]) <= plen &&
						    int'(rt_len[r]) > win_len) begin
							win_len = rt_len[r];
							best_idx = r;
						end
					m.matched = (win_len != 0);
					m.route = best_idx[ROUTE_W-1:0];
					m.length = win_len[LEN_W-1:0];
					pending_matches.push_back(m);
					alive = '1;
					path_pos = '0;
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		match_t exp_m;
		beat_t  b;
		beat_taken <= req_if.valid && req_if.ready && arst_n;
		if (arst_n && req_if.valid && req_if.ready) begin
			b.mode = req_if.mode;
			b.route = req_if.route_index;
			b.pos = req_if.position;
			b.data = req_if.data_byte;
			b.last = req_if.last;
			b.drain = 1'b0;
			track_beat(b);
		end
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			matches_seen <= matches_seen + 1;
			if (pending_matches.size() == 0) begin
				err_count++;
				$display("%0t: unexpected match beat matched=%0d route=%0d length=%0d", $time,
					rsp_if.matched, rsp_if.best_route, rsp_if.best_length);
			end else begin
				exp_m = pending_matches.pop_front();
				if (rsp_if.matched !== exp_m.matched) begin
					err_count++;
					$display("%0t: matched expected %0d actual %0d", $time, exp_m.matched,
						rsp_if.matched);
				end
				if (rsp_if.best_route !== exp_m.route) begin
					err_count++;
					$display("%0t: best_route expected %0d actual %0d", $time, exp_m.route,
						rsp_if.best_route);
				end
				if (rsp_if.best_length !== exp_m.length) begin
					err_count++;
					$display("%0t: best_length expected %0d actual %0d", $time, exp_m.length,
						rsp_if.best_length);
				end
			end
		end
	end

	always @(negedge clk) begin
		drv_cycle <= drv_cycle + 1;
		if (arst_n && (!req_if.valid || beat_taken)) begin
			if (beat_q.size() != 0 && beat_q[0].drain) begin
				req_if.valid <= 1'b0;
				if (pending_matches.size() == 0)
					void'(beat_q.pop_front());
			end else if (beat_q.size() != 0 &&
			             ((drv_cycle >= QUIET_FROM && drv_cycle < QUIET_TO) ||
			              $urandom_range(0, 99) >= 26)) begin
				drv_beat = beat_q.pop_front();
				req_if.valid <= 1'b1;
				req_if.mode <= drv_beat.mode;
				req_if.route_index <= drv_beat.route;
				req_if.position <= drv_beat.pos;
				req_if.data_byte <= drv_beat.data;
				req_if.last <= drv_beat.last;
			end else
				req_if.valid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		snk_cycle <= snk_cycle + 1;
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_if.ready <= 1'b0;
		end else if (!hold_done && matches_seen >= 60) begin
			hold_done <= 1'b1;
			hold_left <= 300;
			rsp_if.ready <= 1'b0;
		end else
			rsp_if.ready <= (snk_cycle >= QUIET_FROM && snk_cycle < QUIET_TO) ||
				$urandom_range(0, 99) >= 26;
	end

	task automatic add_beat(input logic [MODE_W-1:0] mode, input int route, input int pos,
	                        input logic [BYTE_W-1:0] data, input logic last);
		beat_t b;
		b.mode = mode;
		b.route = route[ROUTE_W-1:0];
		b.pos = pos[POS_W-1:0];
		b.data = data;
		b.last = last;
		b.drain = 1'b0;
		if (mode == MODE_PREFIX && pos < MAX_PREFIX - 1) begin
			// hold the length back unless every byte below it is present
			for (int p = 0; p < pos; p++)
				if (!gen_written[route][p])
					b.last = 1'b0;
			gen_store[route][pos] = data;
			gen_written[route][pos] = 1'b1;
			if (b.last)
				gen_len[route] = pos + 1;
		end
		if (mode == MODE_CLEAR)
			foreach (gen_len[r])
				gen_len[r] = 0;
		beat_q.push_back(b);
		n_items++;
	endtask

	task automatic add_drain();
		beat_t b;
		b = '0;
		b.drain = 1'b1;
		beat_q.push_back(b);
	endtask

	function automatic logic [BYTE_W-1:0] rand_byte();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h2F;
			3: return 8'h61;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic int pick_route();
		int r;
		for (int i = 0; i < 16; i++) begin
			r = $urandom_range(0, NUM_ROUTES - 1);
			if (gen_len[r] != 0)
				return r;
		end
		return -1;
	endfunction

	task automatic make_word(input int len, input int src, input int share);
		word_buf.delete();
		for (int i = 0; i < len; i++)
			if (src >= 0 && i < gen_len[src] && i < share)
				word_buf.push_back(gen_store[src][i]);
			else
				word_buf.push_back(rand_byte());
	endtask

	task automatic add_noise();
		case ($urandom_range(0, 9))
			0, 1, 2: add_beat(MODE_UNUSED, $urandom_range(0, 63), $urandom_range(0, 127),
				rand_byte(), 1'($urandom_range(0, 1)));
			3, 4, 5: add_beat(MODE_PREFIX, $urandom_range(0, 63), $urandom_range(0, 127),
				rand_byte(), 1'($urandom_range(0, 1)));
			6, 7, 8: add_beat(MODE_PREFIX, $urandom_range(0, 63), MAX_PREFIX - 1, rand_byte(),
				1'b1);
			default: add_beat(MODE_CLEAR, $urandom_range(0, 63), $urandom_range(0, 127),
				rand_byte(), 1'($urandom_range(0, 1)));
		endcase
	endtask

	task automatic write_route(input int r);
		for (int p = 0; p < word_buf.size(); p++)
			add_beat(MODE_PREFIX, r, p, word_buf[p], p == word_buf.size() - 1);
	endtask

	task automatic send_path();
		for (int i = 0; i < word_buf.size(); i++) begin
			if (i != 0 && $urandom_range(0, 59) == 0)
				add_noise();
			add_beat(MODE_PATH, $urandom_range(0, 63), $urandom_range(0, 127), word_buf[i],
				i == word_buf.size() - 1);
		end
	endtask

	task automatic random_phase();
		int src;
		int len;
		int r;
		if ($urandom_range(0, 3) == 0)
			add_beat(MODE_CLEAR, 0, 0, 8'h00, 1'b0);
		repeat ($urandom_range(1, 10)) begin
			r = $urandom_range(0, NUM_ROUTES - 1);
			len = ($urandom_range(0, 39) == 0) ? $urandom_range(100, MAX_PREFIX - 1)
				: $urandom_range(1, 8);
			src = pick_route();
			make_word(len, src, (src >= 0) ? $urandom_range(0, gen_len[src]) : 0);
			write_route(r);
		end
		repeat ($urandom_range(5, 25)) begin
			src = pick_route();
			if ($urandom_range(0, 79) == 0)
				len = $urandom_range(130, 300);
			else if (src >= 0)
				len = (gen_len[src] > 2 && $urandom_range(0, 3) == 0)
					? $urandom_range(1, gen_len[src]) : gen_len[src] + $urandom_range(0, 3);
			else
				len = $urandom_range(1, 10);
			make_word(len, src, len);
			if ($urandom_range(0, 3) == 0)
				word_buf[$urandom_range(0, len - 1)] = rand_byte();
			send_path();
			if ($urandom_range(0, 4) == 0)
				add_noise();
		end
	endtask

	initial begin
		logic drained_mid;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.mode = MODE_CLEAR;
		req_if.route_index = '0;
		req_if.position = '0;
		req_if.data_byte = '0;
		req_if.last = 1'b0;
		rsp_if.ready = 1'b0;
		beat_taken = 1'b0;
		drv_cycle = 0;
		snk_cycle = 0;
		hold_left = 0;
		hold_done = 1'b0;
		matches_seen = 0;
		err_count = 0;
		n_items = 0;
		drained_mid = 1'b0;
		foreach (rt_len[r]) begin
			rt_len[r] = '0;
			gen_len[r] = 0;
			for (int p = 0; p < MAX_PREFIX; p++)
				gen_written[r][p] = 1'b0;
		end
		alive = '1;
		path_pos = '0;

		add_beat(MODE_PATH, 0, 0, 8'h00, 1'b1);
		add_beat(MODE_PREFIX, 63, 0, 8'hFF, 1'b1);
		add_beat(MODE_PREFIX, 0, 0, 8'h00, 1'b0);
		add_beat(MODE_PREFIX, 0, 1, 8'h00, 1'b1);
		add_beat(MODE_PREFIX, 5, 0, 8'hFF, 1'b1);
		add_beat(MODE_PREFIX, 7, MAX_PREFIX - 1, 8'hA5, 1'b1);
		add_beat(MODE_PREFIX, 7, MAX_PREFIX - 2, 8'h5A, 1'b0);
		add_beat(MODE_UNUSED, 63, 127, 8'hFF, 1'b1);
		add_beat(MODE_PATH, 0, 0, 8'hFF, 1'b1);
		add_beat(MODE_PATH, 0, 0, 8'h00, 1'b0);
		add_beat(MODE_PATH, 0, 0, 8'h00, 1'b1);
		add_beat(MODE_PATH, 0, 0, 8'h00, 1'b1);
		add_beat(MODE_PATH, 0, 0, 8'h12, 1'b1);
		add_beat(MODE_PATH, 0, 0, 8'hFF, 1'b0);
		add_beat(MODE_CLEAR, 0, 0, 8'h00, 1'b0);
		add_beat(MODE_PREFIX, 5, 0, 8'hFF, 1'b1);
		add_beat(MODE_PATH, 0, 0, 8'hFF, 1'b1);
		add_beat(MODE_PATH, 0, 0, 8'hFF, 1'b0);
		add_beat(MODE_PREFIX, 9, 0, 8'h11, 1'b1);
		add_beat(MODE_PATH, 0, 0, 8'h33, 1'b1);
		add_beat(MODE_CLEAR, 63, 127, 8'hFF, 1'b1);
		add_beat(MODE_PATH, 63, 127, 8'hFF, 1'b1);
		add_drain();

		while (n_items < ITEM_TARGET) begin
			random_phase();
			if (!drained_mid && n_items >= ITEM_TARGET / 2) begin
				add_drain();
				drained_mid = 1'b1;
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (beat_q.size() != 0 || req_if.valid)
			@(posedge clk);
		while (pending_matches.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (err_count == 0 && pending_matches.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
